// ===== rtl/core/icl_pkg.sv =====
`default_nettype none
package icl_pkg;

  localparam int NUM_SETS         = 128;
  localparam int LINE_OFFSET_BITS = 6;
  localparam int SET_BITS         = $clog2(NUM_SETS);

  localparam int ADDR_W     = 32;
  localparam int PHYS_W     = 29;
  localparam int TAG_W      = 16;
  localparam int TAG_LSB    = 13;
  localparam int PEN_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [ADDR_W-1:0] UNCACHED_BITS = 32'h3000_0000;
  localparam logic [PHYS_W-1:0] RAM_LIMIT     = 29'h0200_0000;
  localparam logic [ADDR_W-1:0] MIRROR_LOW    = 32'h3010_0000;
  localparam logic [ADDR_W-1:0] MIRROR_HIGH   = 32'h31FF_FFFF;
  localparam logic [ADDR_W-1:0] MIRROR_DELTA  = 32'h1000_0000;

  localparam logic [PEN_W-1:0] MISS_PENALTY_RST     = 8'd40;
  localparam logic [PEN_W-1:0] UNCACHED_PENALTY_RST = 8'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_MISS_PENALTY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNCACHED_PENALTY = 1'd1;

  localparam logic ACT_FETCH = 1'b0;
  localparam logic ACT_INVAL = 1'b1;

  typedef logic [SET_BITS-1:0] set_idx_t;
  typedef logic [TAG_W-1:0]    tag_t;

  typedef struct packed {
    logic [1:0] valid;
    logic [1:0] lfu;
  } icl_meta_t;

  typedef struct packed {
    tag_t       tag0;
    tag_t       tag1;
    logic [1:0] valid;
    logic [1:0] lfu;
  } icl_entry_t;

  typedef struct packed {
    logic     fill;
    logic     inval;
    set_idx_t set;
    logic     way;
    tag_t     tag;
  } icl_upd_t;

  typedef struct packed {
    logic              is_cached;
    logic              hit;
    logic              way_used;
    logic [PEN_W-1:0]  penalty;
    logic [PHYS_W-1:0] phys_address;
  } icl_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/icache_tag_lookup_lfu_top.sv =====
`default_nettype none
// Two-way set-associative instruction-cache tag array with LFU replacement.
// After reset, busy stays high while the valid and LFU bits are cleared,
// one set per cycle; from then on busy stays low and an item (fetch or
// indexed invalidate) is taken at every edge where start is high.
// Each item gives exactly one result: the accepting edge registers the
// tag, valid and LFU reads, and the next edge registers the compare, way
// choice and result. The receiver cannot stall, so the result sits on
// the out ports, marked by out_strobe, for a single cycle. The update of
// the previous item is forwarded into the next lookup, so back-to-back
// items to one set behave in order. Penalty registers may be written only
// while no item is in flight.
module icache_tag_lookup_lfu_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_action,
  input  wire logic [icl_pkg::ADDR_W-1:0]         in_address,
  output logic                                    out_strobe,
  output logic                                    out_is_cached,
  output logic                                    out_hit,
  output logic                                    out_way_used,
  output logic [icl_pkg::PEN_W-1:0]               out_penalty,
  output logic [icl_pkg::PHYS_W-1:0]              out_phys_address,
  input  wire logic                               cfg_we,
  input  wire logic [icl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [icl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [icl_pkg::PEN_W-1:0]  miss_pen_r;
  logic [icl_pkg::PEN_W-1:0]  unc_pen_r;
  logic                       item_vld_r;
  logic                       action_r;
  logic [icl_pkg::ADDR_W-1:0] addr_r;
  logic                       strobe_r;
  icl_pkg::icl_res_t          res_r;

  icl_pkg::set_idx_t   rd_set;
  icl_pkg::set_idx_t   lk_set;
  icl_pkg::icl_entry_t entry;
  icl_pkg::icl_upd_t   upd;
  icl_pkg::icl_res_t   res_nxt;
  logic                accept;
  logic                clearing;

  assign busy   = clearing;
  assign accept = start & ~busy;
  assign rd_set = in_address[icl_pkg::LINE_OFFSET_BITS +: icl_pkg::SET_BITS];
  assign lk_set = addr_r[icl_pkg::LINE_OFFSET_BITS +: icl_pkg::SET_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_pen_r <= icl_pkg::MISS_PENALTY_RST;
      unc_pen_r  <= icl_pkg::UNCACHED_PENALTY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        icl_pkg::CFG_MISS_PENALTY:     miss_pen_r <= cfg_data;
        icl_pkg::CFG_UNCACHED_PENALTY: unc_pen_r  <= cfg_data;
        default: begin
          miss_pen_r <= miss_pen_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      item_vld_r <= accept;
      strobe_r   <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= in_action;
    addr_r   <= in_address;
    res_r    <= res_nxt;
  end

  icl_tag_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_set   (rd_set),
    .lk_set   (lk_set),
    .upd      (upd),
    .entry    (entry),
    .clearing (clearing)
  );

  icl_decide u_decide (
    .item_vld         (item_vld_r),
    .action           (action_r),
    .address          (addr_r),
    .set              (lk_set),
    .entry            (entry),
    .miss_penalty     (miss_pen_r),
    .uncached_penalty (unc_pen_r),
    .res              (res_nxt),
    .upd              (upd)
  );

  assign out_strobe       = strobe_r;
  assign out_is_cached    = res_r.is_cached;
  assign out_hit          = res_r.hit;
  assign out_way_used     = res_r.way_used;
  assign out_penalty      = res_r.penalty;
  assign out_phys_address = res_r.phys_address;

endmodule
`default_nettype wire

// ===== rtl/core/icl_ram.sv =====
`default_nettype none
module icl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/icl_tag_store.sv =====
`default_nettype none
module icl_tag_store (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire icl_pkg::set_idx_t   rd_set,
  input  wire icl_pkg::set_idx_t   lk_set,
  input  wire icl_pkg::icl_upd_t   upd,
  output icl_pkg::icl_entry_t      entry,
  output logic                     clearing
);

  logic              clr_busy_r;
  icl_pkg::set_idx_t clr_set_r;

  logic               fwd_vld_r;
  logic               fwd_meta_vld_r;
  icl_pkg::set_idx_t  fwd_set_r;
  logic               fwd_way_r;
  icl_pkg::tag_t      fwd_tag_r;
  icl_pkg::icl_meta_t fwd_meta_r;

  icl_pkg::tag_t      rd_tag0;
  icl_pkg::tag_t      rd_tag1;
  icl_pkg::icl_meta_t rd_meta;
  logic [1:0]         way_mask;
  icl_pkg::icl_meta_t meta_new;
  logic               meta_we;
  icl_pkg::set_idx_t  meta_waddr;
  icl_pkg::icl_meta_t meta_wdata;
  logic               we0;
  logic               we1;

  assign we0 = upd.fill & ~upd.way;
  assign we1 = upd.fill & upd.way;

  icl_ram #(.WIDTH(icl_pkg::TAG_W), .DEPTH(icl_pkg::NUM_SETS)) u_tag0 (
    .clk   (clk),
    .we    (we0),
    .waddr (upd.set),
    .wdata (upd.tag),
    .raddr (rd_set),
    .rdata (rd_tag0)
  );

  icl_ram #(.WIDTH(icl_pkg::TAG_W), .DEPTH(icl_pkg::NUM_SETS)) u_tag1 (
    .clk   (clk),
    .we    (we1),
    .waddr (upd.set),
    .wdata (upd.tag),
    .raddr (rd_set),
    .rdata (rd_tag1)
  );

  icl_ram #(.WIDTH($bits(icl_pkg::icl_meta_t)), .DEPTH(icl_pkg::NUM_SETS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (rd_set),
    .rdata (rd_meta)
  );

  assign clearing = clr_busy_r;

  // new valid and LFU bits of the set under lookup
  assign way_mask = upd.way ? 2'b10 : 2'b01;

  always_comb begin
    meta_new.valid = entry.valid;
    meta_new.lfu   = entry.lfu;
    if (upd.fill) begin
      meta_new.valid = entry.valid | way_mask;
      meta_new.lfu   = entry.lfu ^ way_mask;
    end else if (upd.inval) begin
      meta_new.valid = entry.valid & ~way_mask;
    end
  end

  // clear one set per cycle after reset
  assign meta_we    = clr_busy_r | upd.fill | upd.inval;
  assign meta_waddr = clr_busy_r ? clr_set_r : upd.set;
  assign meta_wdata = clr_busy_r ? '0 : meta_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r     <= 1'b1;
      clr_set_r      <= '0;
      fwd_vld_r      <= 1'b0;
      fwd_meta_vld_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_set_r <= clr_set_r + 1'b1;
        if (clr_set_r == icl_pkg::set_idx_t'(icl_pkg::NUM_SETS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      fwd_vld_r      <= upd.fill;
      fwd_meta_vld_r <= upd.fill | upd.inval;
    end
  end

  always_ff @(posedge clk) begin
    fwd_set_r  <= upd.set;
    fwd_way_r  <= upd.way;
    fwd_tag_r  <= upd.tag;
    fwd_meta_r <= meta_new;
  end

  // the read issued at the edge of the last update misses that write: forward it
  always_comb begin
    entry.tag0  = rd_tag0;
    entry.tag1  = rd_tag1;
    entry.valid = rd_meta.valid;
    entry.lfu   = rd_meta.lfu;
    if (fwd_meta_vld_r && (fwd_set_r == lk_set)) begin
      entry.valid = fwd_meta_r.valid;
      entry.lfu   = fwd_meta_r.lfu;
    end
    if (fwd_vld_r && (fwd_set_r == lk_set)) begin
      if (fwd_way_r) begin
        entry.tag1 = fwd_tag_r;
      end else begin
        entry.tag0 = fwd_tag_r;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/icl_decide.sv =====
`default_nettype none
module icl_decide (
  input  wire logic                             item_vld,
  input  wire logic                             action,
  input  wire logic [icl_pkg::ADDR_W-1:0]       address,
  input  wire icl_pkg::set_idx_t                set,
  input  wire icl_pkg::icl_entry_t              entry,
  input  wire logic [icl_pkg::PEN_W-1:0]        miss_penalty,
  input  wire logic [icl_pkg::PEN_W-1:0]        uncached_penalty,
  output icl_pkg::icl_res_t                     res,
  output icl_pkg::icl_upd_t                     upd
);

  icl_pkg::tag_t                tag;
  logic                         uncached;
  logic                         hit0;
  logic                         hit1;
  logic                         hit;
  logic                         fill_way;
  logic [icl_pkg::ADDR_W-1:0]   folded;
  logic [icl_pkg::PHYS_W-1:0]   masked;

  assign tag      = address[icl_pkg::TAG_LSB +: icl_pkg::TAG_W];
  assign uncached = |(address & icl_pkg::UNCACHED_BITS);
  assign masked   = address[icl_pkg::PHYS_W-1:0];
  assign hit0     = entry.valid[0] && (entry.tag0 == tag);
  assign hit1     = entry.valid[1] && (entry.tag1 == tag);
  assign hit      = hit0 | hit1;

  always_comb begin
    if (!entry.valid[0]) begin
      fill_way = 1'b0;
    end else if (!entry.valid[1]) begin
      fill_way = 1'b1;
    end else begin
      fill_way = entry.lfu[0] ^ entry.lfu[1];
    end
  end

  // fold the upper mirror window down onto the lower one
  always_comb begin
    if ((address >= icl_pkg::MIRROR_LOW) && (address <= icl_pkg::MIRROR_HIGH)) begin
      folded = address - icl_pkg::MIRROR_DELTA;
    end else begin
      folded = address;
    end
  end

  always_comb begin
    res       = '0;
    upd.fill  = 1'b0;
    upd.inval = 1'b0;
    upd.set   = set;
    upd.way   = fill_way;
    upd.tag   = tag;
    case (action)
      icl_pkg::ACT_INVAL: begin
        upd.inval = item_vld;
        upd.way   = address[0];
      end
      icl_pkg::ACT_FETCH: begin
        if (uncached) begin
          res.phys_address = folded[icl_pkg::PHYS_W-1:0];
          res.penalty      = (masked < icl_pkg::RAM_LIMIT) ? uncached_penalty : '0;
        end else begin
          res.is_cached    = 1'b1;
          res.hit          = hit;
          res.phys_address = masked;
          if (hit) begin
            res.way_used = hit1 & ~hit0;
          end else begin
            res.way_used = fill_way;
            res.penalty  = miss_penalty;
            upd.fill     = item_vld;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule
`default_nettype wire
